/* sv/ftg_pkg.sv */
// Package of the foot trajectory generator: widths, register codes, reset values,
// the item tag carried down the pipeline, the CORDIC angle table and output saturation.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package ftg_pkg;

   localparam int PHASE_W            = 16;
   localparam int OUT_W              = 17;
   localparam int SEG_W              = 2;
   localparam int DIV_W              = 18;
   localparam int MAG_BASE_W         = 36;
   localparam int PHASE_FRAC_DEFAULT = 16;
   localparam int CORDIC_STEPS       = 28;
   localparam int ANG_W              = 34;
   localparam int XY_W               = 34;
   localparam int SC_W               = 20;
   localparam int XM_W               = 37;
   localparam int CSR_IDX_W          = 3;

   localparam logic [31:0] PI_Q30      = 32'd3373259426;
   localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
   localparam logic [31:0] GAIN_Q30    = 32'd652032874;

   localparam logic [CSR_IDX_W-1:0] REG_PATH_MODE     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DUTY_FACTOR   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_STANCE_LENGTH = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SWING_LENGTH  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_LIFT_HEIGHT   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_PHASE_OFFSET  = 3'd5;

   localparam logic [PHASE_W-1:0] DUTY_RESET   = 16'd49152;
   localparam logic [PHASE_W-1:0] STANCE_RESET = 16'd6554;
   localparam logic [PHASE_W-1:0] SWING_RESET  = 16'd6554;
   localparam logic [PHASE_W-1:0] LIFT_RESET   = 16'd3277;

   localparam logic signed [OUT_W-1:0] OUT_MIN = 17'h10000;
   localparam logic signed [OUT_W-1:0] OUT_MAX = 17'h0FFFF;

   typedef enum logic [1:0] {
      KIND_STANCE,
      KIND_ELLIPSE,
      KIND_RECT
   } kind_type;

   typedef struct packed {
      logic                 path_mode;
      logic [PHASE_W-1:0]   duty_factor;
      logic [PHASE_W-1:0]   stance_length;
      logic [PHASE_W-1:0]   swing_length;
      logic [PHASE_W-1:0]   lift_height;
      logic [PHASE_W-1:0]   phase_offset;
   } cfg_type;

   typedef struct packed {
      kind_type                  kind;
      logic [SEG_W-1:0]          seg;
      logic                      q_in_z;
      logic signed [OUT_W-1:0]   fixed;
   } side_type;

   function automatic logic [31:0] atan_step(input int i);
      case (i)
         0:       return 32'd843314857;
         1:       return 32'd497837829;
         2:       return 32'd263043837;
         3:       return 32'd133525159;
         4:       return 32'd67021687;
         5:       return 32'd33543516;
         6:       return 32'd16775851;
         7:       return 32'd8388437;
         8:       return 32'd4194283;
         9:       return 32'd2097149;
         10:      return 32'd1048576;
         default: return 32'd1 << (30 - i);
      endcase
   endfunction

   function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [63:0] v);
      if (v < -64'sd65536) begin
         return OUT_MIN;
      end else if (v > 64'sd65535) begin
         return OUT_MAX;
      end
      return v[OUT_W-1:0];
   endfunction

endpackage

`default_nettype wire

/* sv/ftg_front.sv */
// Front end of the foot trajectory generator: phase wrap, segment choice and the
// numerator and divisor of the one division each transaction needs. Uses ftg_pkg.
`default_nettype none

module ftg_front #(
   parameter int PHASE_FRAC_BITS = ftg_pkg::PHASE_FRAC_DEFAULT,
   parameter int NW              = ftg_pkg::MAG_BASE_W
) (
   input  logic                            clock,
   input  logic                            reset,
   input  ftg_pkg::cfg_type                cfg,
   input  logic                            in_valid,
   input  logic [ftg_pkg::PHASE_W-1:0]     in_phase,
   output logic                            out_valid,
   output ftg_pkg::side_type               out_side,
   output logic                            out_neg,
   output logic [NW-1:0]                   out_mag,
   output logic [ftg_pkg::DIV_W-1:0]       out_div
);
   import ftg_pkg::*;

   localparam int NS = NW + 1;

   logic                 v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;
   logic [PHASE_W-1:0]   t1_ff, t1_in;
   logic [PHASE_W-1:0]   t2_ff, s2_ff, s2_in;
   logic                 st2_ff, st2_in, st3_ff;
   logic [PHASE_W:0]     lsd2_ff, lsd2_in;
   logic [PHASE_W-1:0]   s3_ff;
   logic [31:0]          lt3_ff, lt3_in;
   logic [32:0]          bl3_ff, bl3_in, hw3_ff, hw3_in;
   logic [33:0]          ds3_ff, ds3_in, hlw3_ff, hlw3_in;
   logic [34:0]          a2_3_ff, a2_3_in, a3_3_ff, a3_3_in;
   logic [PHASE_W:0]     w_c;
   logic [17:0]          hh2;
   logic signed [NS-1:0] n4_ff, n4_in, nb5_ff, nb5_in;
   logic [PHASE_W:0]     bias4_ff, bias4_in;
   logic [DIV_W-1:0]     div4_ff, div4_in, div5_ff, div6_ff;
   side_type             side4_ff, side4_in, side5_ff, side6_ff;
   logic                 neg6_ff, neg6_in;
   logic [NW-1:0]        mag6_ff, mag6_in;
   logic signed [NS-1:0] two_ds;

   always_comb begin
      t1_in   = 16'(in_phase + cfg.phase_offset);
      st2_in  = t1_ff < cfg.duty_factor;
      s2_in   = 16'(t1_ff - cfg.duty_factor);
      lsd2_in = 17'(cfg.stance_length) + ((cfg.swing_length > cfg.stance_length) ?
                17'(cfg.swing_length - cfg.stance_length) :
                17'(cfg.stance_length - cfg.swing_length));
      w_c     = 17'h10000 - 17'(cfg.duty_factor);
      hh2     = 18'({cfg.lift_height, 1'b0}) + 18'(cfg.stance_length);
      lt3_in  = 32'(cfg.stance_length) * 32'(t2_ff);
      bl3_in  = 33'(cfg.duty_factor) *
                33'(cfg.path_mode ? 17'(cfg.stance_length) : lsd2_ff);
      ds3_in  = 34'(hh2) * 34'(s2_ff);
      hw3_in  = 33'(cfg.lift_height) * 33'(w_c);
      hlw3_in = 34'(17'(cfg.lift_height) + 17'(cfg.stance_length)) * 34'(w_c);
      a2_3_in = 35'(hh2) * 35'(w_c);
      a3_3_in = 35'(19'(cfg.lift_height) + 19'({cfg.lift_height, 1'b0}) +
                19'({cfg.stance_length, 1'b0})) * 35'(w_c);
   end

   always_comb begin
      two_ds   = $signed(NS'({ds3_ff, 1'b0}));
      n4_in    = '0;
      bias4_in = '0;
      div4_in  = '0;
      side4_in = '0;
      if (st3_ff) begin
         n4_in         = $signed(NS'({lt3_ff, 1'b0})) - $signed(NS'(bl3_ff));
         bias4_in      = 17'(cfg.duty_factor);
         div4_in       = 18'({cfg.duty_factor, 1'b0});
         side4_in.kind = KIND_STANCE;
         side4_in.seg  = 2'd0;
         side4_in.fixed = cfg.path_mode ? (17'd0 - 17'(cfg.lift_height[15:1])) : 17'd0;
      end else if (!cfg.path_mode) begin
         n4_in         = $signed(NS'({s3_ff, {PHASE_FRAC_BITS{1'b0}}}));
         div4_in       = 18'(w_c);
         side4_in.kind = KIND_ELLIPSE;
         side4_in.seg  = 2'd1;
      end else begin
         bias4_in      = w_c;
         div4_in       = {w_c, 1'b0};
         side4_in.kind = KIND_RECT;
         if (ds3_ff < {1'b0, hw3_ff}) begin
            n4_in           = two_ds - $signed(NS'(hw3_ff));
            side4_in.seg    = 2'd1;
            side4_in.q_in_z = 1'b1;
            side4_in.fixed  = 17'((17'(cfg.stance_length) + 17'd1) >> 1);
         end else if (ds3_ff < hlw3_ff) begin
            n4_in           = $signed(NS'(a2_3_ff)) - two_ds;
            side4_in.seg    = 2'd2;
            side4_in.fixed  = 17'((17'(cfg.lift_height) + 17'd1) >> 1);
         end else begin
            n4_in           = $signed(NS'(a3_3_ff)) - two_ds;
            side4_in.seg    = 2'd3;
            side4_in.q_in_z = 1'b1;
            side4_in.fixed  = 17'd0 - 17'(cfg.stance_length[15:1]);
         end
      end
   end

   always_comb begin
      nb5_in  = n4_ff + $signed(NS'(bias4_ff));
      neg6_in = nb5_ff[NS-1];
      mag6_in = neg6_in ? NW'(-nb5_ff) : NW'(nb5_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
      end
      t1_ff    <= t1_in;
      t2_ff    <= t1_ff;
      st2_ff   <= st2_in;
      s2_ff    <= s2_in;
      lsd2_ff  <= lsd2_in;
      st3_ff   <= st2_ff;
      s3_ff    <= s2_ff;
      lt3_ff   <= lt3_in;
      bl3_ff   <= bl3_in;
      ds3_ff   <= ds3_in;
      hw3_ff   <= hw3_in;
      hlw3_ff  <= hlw3_in;
      a2_3_ff  <= a2_3_in;
      a3_3_ff  <= a3_3_in;
      n4_ff    <= n4_in;
      bias4_ff <= bias4_in;
      div4_ff  <= div4_in;
      side4_ff <= side4_in;
      nb5_ff   <= nb5_in;
      div5_ff  <= div4_ff;
      side5_ff <= side4_ff;
      neg6_ff  <= neg6_in;
      mag6_ff  <= mag6_in;
      div6_ff  <= div5_ff;
      side6_ff <= side5_ff;
   end

   assign out_valid = v6_ff;
   assign out_side  = side6_ff;
   assign out_neg   = neg6_ff;
   assign out_mag   = mag6_ff;
   assign out_div   = div6_ff;

endmodule

`default_nettype wire

/* sv/ftg_div.sv */
// Pipelined restoring divider of the foot trajectory generator, one quotient bit
// per stage, with the transaction tag riding alongside. Uses ftg_pkg.
`default_nettype none

module ftg_div #(
   parameter int NW = ftg_pkg::MAG_BASE_W
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  ftg_pkg::side_type          in_side,
   input  logic                       in_neg,
   input  logic [NW-1:0]              in_mag,
   input  logic [ftg_pkg::DIV_W-1:0]  in_div,
   output logic                       out_valid,
   output ftg_pkg::side_type          out_side,
   output logic                       out_neg,
   output logic [NW-1:0]              out_quot,
   output logic                       out_rem_nz
);
   import ftg_pkg::*;

   logic             v_ff    [NW];
   logic [DIV_W-1:0] rem_ff  [NW];
   logic [NW-1:0]    dq_ff   [NW];
   logic [DIV_W-1:0] dv_ff   [NW];
   side_type         side_ff [NW];
   logic             neg_ff  [NW];

   for (genvar k = 0; k < NW; k++) begin : g_stage
      logic             v_prev;
      logic [DIV_W-1:0] rem_prev, dv_prev, rem_in;
      logic [NW-1:0]    dq_prev, dq_in;
      side_type         side_prev;
      logic             neg_prev, ge;
      logic [DIV_W:0]   trial, diff;

      if (k == 0) begin : g_first
         assign v_prev    = in_valid;
         assign rem_prev  = '0;
         assign dq_prev   = in_mag;
         assign dv_prev   = in_div;
         assign side_prev = in_side;
         assign neg_prev  = in_neg;
      end else begin : g_next
         assign v_prev    = v_ff[k-1];
         assign rem_prev  = rem_ff[k-1];
         assign dq_prev   = dq_ff[k-1];
         assign dv_prev   = dv_ff[k-1];
         assign side_prev = side_ff[k-1];
         assign neg_prev  = neg_ff[k-1];
      end

      always_comb begin
         trial  = {rem_prev, dq_prev[NW-1]};
         diff   = trial - {1'b0, dv_prev};
         ge     = !diff[DIV_W];
         rem_in = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
         dq_in  = {dq_prev[NW-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else begin
            v_ff[k] <= v_prev;
         end
         rem_ff[k]  <= rem_in;
         dq_ff[k]   <= dq_in;
         dv_ff[k]   <= dv_prev;
         side_ff[k] <= side_prev;
         neg_ff[k]  <= neg_prev;
      end
   end

   assign out_valid  = v_ff[NW-1];
   assign out_side   = side_ff[NW-1];
   assign out_neg    = neg_ff[NW-1];
   assign out_quot   = dq_ff[NW-1];
   assign out_rem_nz = |rem_ff[NW-1];

endmodule

`default_nettype wire

/* sv/ftg_cordic.sv */
// Back end of the foot trajectory generator: quotient sign fix and saturation,
// swing angle, a pipelined 28-step rotation CORDIC and the ellipse scaling. Uses ftg_pkg.
`default_nettype none

module ftg_cordic #(
   parameter int PHASE_FRAC_BITS = ftg_pkg::PHASE_FRAC_DEFAULT,
   parameter int NW              = ftg_pkg::MAG_BASE_W
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  ftg_pkg::cfg_type                     cfg,
   input  logic                                 in_valid,
   input  ftg_pkg::side_type                    in_side,
   input  logic                                 in_neg,
   input  logic [NW-1:0]                        in_quot,
   input  logic                                 in_rem_nz,
   output logic                                 out_valid,
   output ftg_pkg::side_type                    out_side,
   output logic signed [ftg_pkg::OUT_W-1:0]     out_q,
   output logic signed [ftg_pkg::XM_W-1:0]      out_xm,
   output logic signed [ftg_pkg::XM_W-1:0]      out_zm
);
   import ftg_pkg::*;

   localparam int QW = NW + 1;
   localparam int PW = 32 + PHASE_FRAC_BITS;

   logic                     va_ff, vb_ff, vc_ff, vr_ff, vm_ff;
   side_type                 sa_ff, sb_ff, sc_ff, sr_ff, sm_ff;
   logic signed [QW-1:0]     qa_ff, qa_in;
   logic [PHASE_FRAC_BITS-1:0] ua_ff;
   logic [PW-1:0]            prod_ff, prod_in;
   logic signed [OUT_W-1:0]  qb_ff, qc_ff, qr_ff, qm_ff;
   logic signed [ANG_W-1:0]  rest0_ff, rest0_in;
   logic signed [XY_W-1:0]   cx0_ff, cy0_ff;
   logic signed [SC_W-1:0]   s16_ff, s16_in, c16_ff, c16_in;
   logic signed [XM_W-1:0]   xm_ff, xm_in, zm_ff, zm_in, lw_s, h_s;
   logic signed [XY_W-1:0]   cx_rnd, cy_rnd;

   logic                     v_ff    [CORDIC_STEPS];
   side_type                 side_ff [CORDIC_STEPS];
   logic signed [OUT_W-1:0]  q_ff    [CORDIC_STEPS];
   logic signed [ANG_W-1:0]  rest_ff [CORDIC_STEPS];
   logic signed [XY_W-1:0]   cx_ff   [CORDIC_STEPS];
   logic signed [XY_W-1:0]   cy_ff   [CORDIC_STEPS];

   always_comb begin
      qa_in    = in_neg ? -$signed(QW'(in_quot) + QW'(in_rem_nz)) : $signed(QW'(in_quot));
      prod_in  = PW'(PI_Q30) * PW'(ua_ff);
      rest0_in = $signed(ANG_W'(prod_ff[PW-1:PHASE_FRAC_BITS])) -
                 $signed(ANG_W'(HALF_PI_Q30));
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
      logic                    v_prev;
      side_type                side_prev;
      logic signed [OUT_W-1:0] q_prev;
      logic signed [ANG_W-1:0] rest_prev, rest_in, step;
      logic signed [XY_W-1:0]  cx_prev, cy_prev, cx_in, cy_in, dx, dy;

      if (i == 0) begin : g_first
         assign v_prev    = vc_ff;
         assign side_prev = sc_ff;
         assign q_prev    = qc_ff;
         assign rest_prev = rest0_ff;
         assign cx_prev   = cx0_ff;
         assign cy_prev   = cy0_ff;
      end else begin : g_next
         assign v_prev    = v_ff[i-1];
         assign side_prev = side_ff[i-1];
         assign q_prev    = q_ff[i-1];
         assign rest_prev = rest_ff[i-1];
         assign cx_prev   = cx_ff[i-1];
         assign cy_prev   = cy_ff[i-1];
      end

      always_comb begin
         step = $signed(ANG_W'(atan_step(i)));
         dx   = cy_prev >>> i;
         dy   = cx_prev >>> i;
         if (!rest_prev[ANG_W-1]) begin
            cx_in   = cx_prev - dx;
            cy_in   = cy_prev + dy;
            rest_in = rest_prev - step;
         end else begin
            cx_in   = cx_prev + dx;
            cy_in   = cy_prev - dy;
            rest_in = rest_prev + step;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i] <= 1'b0;
         end else begin
            v_ff[i] <= v_prev;
         end
         side_ff[i] <= side_prev;
         q_ff[i]    <= q_prev;
         rest_ff[i] <= rest_in;
         cx_ff[i]   <= cx_in;
         cy_ff[i]   <= cy_in;
      end
   end

   always_comb begin
      cx_rnd = (cx_ff[CORDIC_STEPS-1] + XY_W'(8192)) >>> 14;
      cy_rnd = (cy_ff[CORDIC_STEPS-1] + XY_W'(8192)) >>> 14;
      s16_in = cx_rnd[SC_W-1:0];
      c16_in = -cy_rnd[SC_W-1:0];
      lw_s   = $signed(XM_W'(cfg.swing_length));
      h_s    = $signed(XM_W'(cfg.lift_height));
      xm_in  = lw_s * XM_W'(c16_ff) + $signed(XM_W'(65536));
      zm_in  = h_s * XM_W'(s16_ff) + $signed(XM_W'(32768));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
         vr_ff <= 1'b0;
         vm_ff <= 1'b0;
      end else begin
         va_ff <= in_valid;
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
         vr_ff <= v_ff[CORDIC_STEPS-1];
         vm_ff <= vr_ff;
      end
      sa_ff    <= in_side;
      qa_ff    <= qa_in;
      ua_ff    <= in_quot[PHASE_FRAC_BITS-1:0];
      sb_ff    <= sa_ff;
      prod_ff  <= prod_in;
      qb_ff    <= sat_out(64'(qa_ff));
      sc_ff    <= sb_ff;
      qc_ff    <= qb_ff;
      rest0_ff <= rest0_in;
      cx0_ff   <= $signed(XY_W'(GAIN_Q30));
      cy0_ff   <= '0;
      sr_ff    <= side_ff[CORDIC_STEPS-1];
      qr_ff    <= q_ff[CORDIC_STEPS-1];
      s16_ff   <= s16_in;
      c16_ff   <= c16_in;
      sm_ff    <= sr_ff;
      qm_ff    <= qr_ff;
      xm_ff    <= xm_in;
      zm_ff    <= zm_in;
   end

   assign out_valid = vm_ff;
   assign out_side  = sm_ff;
   assign out_q     = qm_ff;
   assign out_xm    = xm_ff;
   assign out_zm    = zm_ff;

endmodule

`default_nettype wire

/* sv/leg_foot_trajectory_generator.sv */
// Top level of the foot trajectory generator: configuration registers, the three
// pipeline sections and the output stage. Uses ftg_pkg, ftg_front, ftg_div, ftg_cordic.
//
// One transaction enters on every clock cycle at which start is high; busy stays low,
// so the block never refuses a transaction. Each result appears on the rsp_ ports for
// one cycle with rsp_strobe high, after it has passed the front end, the divider, the
// back end and the output register. Results leave in order; the receiver cannot stall.
// Most of the pipeline lies in the restoring divider, one quotient bit per stage, and the
// 28-stage CORDIC. Configuration is to be written only when no transaction is in flight.
`default_nettype none

module leg_foot_trajectory_generator #(
   parameter int PHASE_FRAC_BITS = ftg_pkg::PHASE_FRAC_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [ftg_pkg::PHASE_W-1:0]          req_gait_phase,
   output logic                                 rsp_strobe,
   output logic signed [ftg_pkg::OUT_W-1:0]     rsp_x_position,
   output logic signed [ftg_pkg::OUT_W-1:0]     rsp_z_position,
   output logic [ftg_pkg::SEG_W-1:0]            rsp_segment,
   input  logic                                 csr_write_enable,
   input  logic [ftg_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [ftg_pkg::PHASE_W-1:0]          csr_write_data
);
   import ftg_pkg::*;

   localparam int NW = (16 + PHASE_FRAC_BITS > MAG_BASE_W) ? 16 + PHASE_FRAC_BITS : MAG_BASE_W;

   cfg_type                 cfg_ff, cfg_in;
   logic                    f_valid, d_valid, c_valid;
   side_type                f_side, d_side, c_side;
   logic                    f_neg, d_neg, d_rem_nz;
   logic [NW-1:0]           f_mag, d_quot;
   logic [DIV_W-1:0]        f_div;
   logic signed [OUT_W-1:0] c_q;
   logic signed [XM_W-1:0]  c_xm, c_zm;
   logic                    strobe_ff;
   logic signed [OUT_W-1:0] x_ff, x_in, z_ff, z_in;
   logic [SEG_W-1:0]        seg_ff;

   assign busy = 1'b0;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            REG_PATH_MODE:     cfg_in.path_mode     = csr_write_data[0];
            REG_DUTY_FACTOR:   cfg_in.duty_factor   = csr_write_data;
            REG_STANCE_LENGTH: cfg_in.stance_length = csr_write_data;
            REG_SWING_LENGTH:  cfg_in.swing_length  = csr_write_data;
            REG_LIFT_HEIGHT:   cfg_in.lift_height   = csr_write_data;
            REG_PHASE_OFFSET:  cfg_in.phase_offset  = csr_write_data;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   ftg_front #(.PHASE_FRAC_BITS(PHASE_FRAC_BITS), .NW(NW)) u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (start & ~busy),
      .in_phase  (req_gait_phase),
      .out_valid (f_valid),
      .out_side  (f_side),
      .out_neg   (f_neg),
      .out_mag   (f_mag),
      .out_div   (f_div)
   );

   ftg_div #(.NW(NW)) u_div (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (f_valid),
      .in_side    (f_side),
      .in_neg     (f_neg),
      .in_mag     (f_mag),
      .in_div     (f_div),
      .out_valid  (d_valid),
      .out_side   (d_side),
      .out_neg    (d_neg),
      .out_quot   (d_quot),
      .out_rem_nz (d_rem_nz)
   );

   ftg_cordic #(.PHASE_FRAC_BITS(PHASE_FRAC_BITS), .NW(NW)) u_cordic (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (d_valid),
      .in_side   (d_side),
      .in_neg    (d_neg),
      .in_quot   (d_quot),
      .in_rem_nz (d_rem_nz),
      .out_valid (c_valid),
      .out_side  (c_side),
      .out_q     (c_q),
      .out_xm    (c_xm),
      .out_zm    (c_zm)
   );

   always_comb begin
      case (c_side.kind)
         KIND_ELLIPSE: begin
            x_in = sat_out(64'(c_xm >>> 17));
            z_in = sat_out(64'(c_zm >>> 16));
         end
         KIND_RECT: begin
            x_in = c_side.q_in_z ? c_side.fixed : c_q;
            z_in = c_side.q_in_z ? c_q : c_side.fixed;
         end
         default: begin
            x_in = c_q;
            z_in = c_side.fixed;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.path_mode     <= 1'b0;
         cfg_ff.duty_factor   <= DUTY_RESET;
         cfg_ff.stance_length <= STANCE_RESET;
         cfg_ff.swing_length  <= SWING_RESET;
         cfg_ff.lift_height   <= LIFT_RESET;
         cfg_ff.phase_offset  <= '0;
         strobe_ff            <= 1'b0;
      end else begin
         cfg_ff    <= cfg_in;
         strobe_ff <= c_valid;
      end
      x_ff   <= x_in;
      z_ff   <= z_in;
      seg_ff <= c_side.seg;
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_x_position = x_ff;
   assign rsp_z_position = z_ff;
   assign rsp_segment    = seg_ff;

endmodule

`default_nettype wire
